// ===== hw/rtl/hdt_pkg.sv =====
`default_nettype none
package hdt_pkg;

    localparam logic [63:0] PI_Q62        = 64'hC90FDAA22168C235;
    localparam logic [63:0] RAD_K         = (PI_Q62 + 64'd900000000) / 64'd1800000000;
    localparam logic [63:0] INV_GAIN_Q31  = 64'd1304065748;
    localparam logic [23:0] EARTH_DIAM_M  = 24'd12742000;
    localparam logic [24:0] MAX_DIST_M    = 25'd20015087;

    localparam logic signed [33:0] DEG7_FULL    = 34'sd3600000000;
    localparam logic signed [33:0] DEG7_HALF    = 34'sd1800000000;
    localparam logic signed [33:0] DEG7_QUARTER = 34'sd900000000;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [1:0] {
        CFG_TARGET_LAT   = 2'd0,
        CFG_TARGET_LON   = 2'd1,
        CFG_TARGET_VALID = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic               no_target;
        logic signed [30:0] lat1;
        logic signed [30:0] lat2;
        logic signed [33:0] dlat;
        logic signed [33:0] dlon;
    } t_item;

    // atan(2^-i) in q62 from the arctangent series
    function automatic logic [63:0] atan_pow2_q62(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned e;
        sum = '0;
        if (i == 0) begin
            return (PI_Q62 + 64'd2) >> 2;
        end
        for (int unsigned k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                sum  = k[0] ? sum - term : sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] step_angle(input int unsigned i, input int unsigned f);
        logic [63:0] t;
        t = atan_pow2_q62(i);
        return (t + (64'd1 << (61 - f))) >> (62 - f);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hdt_fifo.sv =====
`default_nettype none
module hdt_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hdt_pkg::t_item i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output hdt_pkg::t_item     o_data
);
    import hdt_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hdt_front.sv =====
`default_nettype none
module hdt_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hdt_pkg::t_cfg_wr   i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [30:0] i_lat,
    input  wire logic signed [31:0] i_lon,
    input  wire logic               i_full,
    output logic                    o_push,
    output hdt_pkg::t_item          o_item
);
    import hdt_pkg::*;

    logic signed [30:0] r_tlat;
    logic signed [31:0] r_tlon;
    logic               r_tvalid;
    logic               r_v;
    t_item              r_item;
    t_item              n_item;

    assign o_ready = !r_v || !i_full;
    assign o_push  = r_v && !i_full;
    assign o_item  = r_item;

    always_comb begin
        n_item.no_target = !r_tvalid;
        n_item.lat1      = i_lat;
        n_item.lat2      = r_tlat;
        n_item.dlat      = 34'(r_tlat) - 34'(i_lat);
        n_item.dlon      = 34'(r_tlon) - 34'(i_lon);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlat   <= '0;
            r_tlon   <= '0;
            r_tvalid <= 1'b0;
            r_v      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_TARGET_LAT:   r_tlat   <= i_cfg.data[30:0];
                    CFG_TARGET_LON:   r_tlon   <= i_cfg.data;
                    CFG_TARGET_VALID: r_tvalid <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                r_v <= 1'b1;
            end else if (o_push) begin
                r_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hdt_cordic.sv =====
`default_nettype none
module hdt_cordic #(
    parameter int W     = 32,
    parameter int STEPS = 24,
    parameter int F     = 29
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic                i_vec,
    input  wire logic signed [W-1:0] i_x,
    input  wire logic signed [W-1:0] i_y,
    input  wire logic signed [W-1:0] i_z,
    output logic signed [W-1:0]      o_x,
    output logic signed [W-1:0]      o_y,
    output logic signed [W-1:0]      o_z
);
    import hdt_pkg::*;

    logic signed [W-1:0] r_x [STEPS];
    logic signed [W-1:0] r_y [STEPS];
    logic signed [W-1:0] r_z [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [63:0]         A64 = step_angle(k, F);
        localparam logic signed [W-1:0] A   = W'(A64);
        logic signed [W-1:0] p_x, p_y, p_z, dx, dy;
        logic                pos;

        if (k == 0) begin : g_first
            assign p_x = i_x;
            assign p_y = i_y;
            assign p_z = i_z;
        end else begin : g_next
            assign p_x = r_x[k-1];
            assign p_y = r_y[k-1];
            assign p_z = r_z[k-1];
        end

        // rotation steers on the residual angle, vectoring on the sign of y
        assign pos = i_vec ? p_y[W-1] : !p_z[W-1];
        assign dx  = p_y >>> k;
        assign dy  = p_x >>> k;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= pos ? p_x - dx : p_x + dx;
                r_y[k] <= pos ? p_y + dy : p_y - dy;
                r_z[k] <= pos ? p_z - A  : p_z + A;
            end
        end
    end

    assign o_x = r_x[STEPS-1];
    assign o_y = r_y[STEPS-1];
    assign o_z = r_z[STEPS-1];
endmodule
`default_nettype wire

// ===== hw/rtl/hdt_isqrt.sv =====
`default_nettype none
module hdt_isqrt #(
    parameter int F = 29
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [2*F:0] i_v,
    output logic [F:0]        o_r
);
    localparam int RW = 2*F + 2;

    logic [RW-1:0] r_v [F];
    logic [RW-1:0] r_r [F+1];

    for (genvar k = 0; k <= F; k++) begin : g_step
        localparam logic [RW-1:0] B = RW'(1) << (2 * (F - k));
        logic [RW-1:0] p_v, p_r;
        logic          take;

        if (k == 0) begin : g_first
            assign p_v = RW'(i_v);
            assign p_r = '0;
        end else begin : g_next
            assign p_v = r_v[k-1];
            assign p_r = r_r[k-1];
        end

        assign take = (p_v >= p_r + B);

        if (k < F) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k] <= take ? p_v - (p_r + B) : p_v;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k] <= take ? (p_r >> 1) + B : p_r >> 1;
            end
        end
    end

    assign o_r = r_r[F][F:0];
endmodule
`default_nettype wire

// ===== hw/rtl/hdt_back.sv =====
`default_nettype none
module hdt_back #(
    parameter int STEPS = 24,
    parameter int F     = 29
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire hdt_pkg::t_item i_item,
    output logic                o_pop,
    input  wire logic           i_ready,
    output logic                o_valid,
    output logic [24:0]         o_distance,
    output logic                o_no_target
);
    import hdt_pkg::*;

    localparam int S   = STEPS;
    localparam int AW  = F + 3;
    localparam int CW  = F + 2;
    localparam int PW  = 2*F + 4;
    localparam int QW  = 2*F + 1;
    localparam int ZPW = AW - 1 + 24;
    localparam int DW  = ZPW - F;
    localparam int L   = 2*S + F + 13;

    localparam logic signed [AW-1:0] ONE_A   = AW'(64'd1 << F);
    localparam logic signed [PW-1:0] ONEQ2_P = PW'(64'd1 << (2*F));
    localparam logic [QW-1:0]        ONEQ2_Q = QW'(64'd1 << (2*F));
    localparam logic signed [PW-1:0] HALF_P  = PW'(64'd1 << (F-1));
    localparam logic [ZPW-1:0]       HALF_Z  = ZPW'(64'd1 << (F-1));
    localparam logic signed [AW-1:0] X0      =
        AW'((INV_GAIN_Q31 + (64'd1 << (30-F))) >> (31-F));
    localparam logic [31:0]          KL      = RAD_K[31:0];
    localparam logic [63:0]          KH      = RAD_K >> 32;
    localparam logic [63:0]          RND_H   = 64'd1 << (62-F);
    localparam logic [63:0]          RND_C   = 64'd1 << (61-F);

    logic adv;
    logic r_ov;
    logic r_ont;
    logic [24:0] r_od;

    assign adv         = !r_ov || i_ready;
    assign o_pop       = adv && i_valid;
    assign o_valid     = r_ov;
    assign o_distance  = r_od;
    assign o_no_target = r_ont;

    // valid and no-target travel beside the datapath
    logic r_vl [L];
    logic r_nt [L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < L; j++) begin
                r_vl[j] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (adv) begin
            r_vl[0] <= i_valid;
            for (int j = 1; j < L; j++) begin
                r_vl[j] <= r_vl[j-1];
            end
            r_ov <= r_vl[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nt[0] <= i_item.no_target;
            for (int j = 1; j < L; j++) begin
                r_nt[j] <= r_nt[j-1];
            end
        end
    end

    // angle preparation
    logic signed [33:0] r1_m [2];
    logic [30:0]        r1_ma [2];
    logic signed [33:0] r2_m [2];
    logic [30:0]        r2_mc [2];
    logic [1:0]         r2_ng, r3_ng, r4_ng, r5_ng;
    logic [30:0]        r3_m [4];
    logic [63:0]        r4_lo [4];
    logic [30:0]        r4_hi [4];
    logic signed [AW-1:0] r5_ang [4];
    logic [1:0]         r_ngd [S];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // wrap into one turn
            r1_m[0]  <= i_item.dlat[33] ? i_item.dlat + DEG7_FULL : i_item.dlat;
            r1_m[1]  <= i_item.dlon[33] ? i_item.dlon + DEG7_FULL : i_item.dlon;
            r1_ma[0] <= i_item.lat1[30] ? 31'(-i_item.lat1) : 31'(i_item.lat1);
            r1_ma[1] <= i_item.lat2[30] ? 31'(-i_item.lat2) : 31'(i_item.lat2);

            for (int j = 0; j < 2; j++) begin
                if (r1_m[j][33]) begin
                    r2_m[j] <= r1_m[j] + DEG7_FULL;
                end else if (r1_m[j] >= DEG7_FULL) begin
                    r2_m[j] <= r1_m[j] - DEG7_FULL;
                end else begin
                    r2_m[j] <= r1_m[j];
                end
                // reflect latitude beyond the pole
                r2_ng[j] <= ($signed({3'b000, r1_ma[j]}) > DEG7_QUARTER);
                r2_mc[j] <= ($signed({3'b000, r1_ma[j]}) > DEG7_QUARTER) ?
                            31'(DEG7_HALF - $signed({3'b000, r1_ma[j]})) : r1_ma[j];
            end

            for (int j = 0; j < 2; j++) begin
                r3_m[j] <= (r2_m[j] > DEG7_HALF) ? 31'(DEG7_FULL - r2_m[j]) : 31'(r2_m[j]);
                r3_m[j+2] <= r2_mc[j];
            end
            r3_ng <= r2_ng;

            for (int j = 0; j < 4; j++) begin
                r4_lo[j] <= 64'(r3_m[j]) * 64'(KL);
                r4_hi[j] <= r3_m[j];
            end
            r4_ng <= r3_ng;

            for (int j = 0; j < 4; j++) begin
                if (j < 2) begin
                    r5_ang[j] <= AW'((((64'(r4_hi[j]) * KH) << 32) + r4_lo[j] + RND_H)
                                     >> (63-F));
                end else begin
                    r5_ang[j] <= AW'((((64'(r4_hi[j]) * KH) << 32) + r4_lo[j] + RND_C)
                                     >> (62-F));
                end
            end
            r5_ng <= r4_ng;

            r_ngd[0] <= r5_ng;
            for (int j = 1; j < S; j++) begin
                r_ngd[j] <= r_ngd[j-1];
            end
        end
    end

    // sine of the half differences, cosine of both latitudes
    logic signed [AW-1:0] c_x [4];
    logic signed [AW-1:0] c_y [4];

    for (genvar g = 0; g < 4; g++) begin : g_rot
        hdt_cordic #(.W(AW), .STEPS(S), .F(F)) u_rot (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_vec (1'b0),
            .i_x   (X0),
            .i_y   ('0),
            .i_z   (r5_ang[g]),
            .o_x   (c_x[g]),
            .o_y   (c_y[g]),
            .o_z   ()
        );
    end

    function automatic logic signed [CW-1:0] clamp_c(input logic signed [AW-1:0] v,
                                                     input logic sine);
        logic signed [AW-1:0] lo;
        lo = sine ? '0 : -ONE_A;
        if (v < lo) begin
            return CW'(lo);
        end
        if (v > ONE_A) begin
            return CW'(ONE_A);
        end
        return CW'(v);
    endfunction

    logic signed [CW-1:0] r6_s1, r6_s2, r6_c1, r6_c2;
    logic signed [CW-1:0] r7_cc, r7_s2, r8_u, r8_s2;
    logic signed [PW-1:0] r7_ss, r8_ss, r9_ss, r9_us;
    logic signed [PW-1:0] p_cc, p_u, sum_a;
    logic [QW-1:0]        r10_a, r11_ya, r11_xa;

    assign p_cc  = PW'(r6_c1) * PW'(r6_c2);
    assign p_u   = PW'(r7_cc) * PW'(r7_s2);
    assign sum_a = r9_ss + r9_us;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_s1 <= clamp_c(c_y[0], 1'b1);
            r6_s2 <= clamp_c(c_y[1], 1'b1);
            r6_c1 <= r_ngd[S-1][0] ? -clamp_c(c_x[2], 1'b0) : clamp_c(c_x[2], 1'b0);
            r6_c2 <= r_ngd[S-1][1] ? -clamp_c(c_x[3], 1'b0) : clamp_c(c_x[3], 1'b0);

            r7_cc <= CW'((p_cc + HALF_P) >>> F);
            r7_ss <= PW'(r6_s1) * PW'(r6_s1);
            r7_s2 <= r6_s2;

            r8_u  <= CW'((p_u + HALF_P) >>> F);
            r8_ss <= r7_ss;
            r8_s2 <= r7_s2;

            r9_us <= PW'(r8_u) * PW'(r8_s2);
            r9_ss <= r8_ss;

            if (sum_a[PW-1]) begin
                r10_a <= '0;
            end else if (sum_a > ONEQ2_P) begin
                r10_a <= ONEQ2_Q;
            end else begin
                r10_a <= QW'(sum_a);
            end

            r11_ya <= r10_a;
            r11_xa <= ONEQ2_Q - r10_a;
        end
    end

    logic [F:0] q_y, q_x;

    hdt_isqrt #(.F(F)) u_sqrt_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_v   (r11_ya),
        .o_r   (q_y)
    );

    hdt_isqrt #(.F(F)) u_sqrt_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_v   (r11_xa),
        .o_r   (q_x)
    );

    logic signed [AW-1:0] v_z;

    hdt_cordic #(.W(AW), .STEPS(S), .F(F)) u_atan (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_vec (1'b1),
        .i_x   ($signed(AW'(q_x))),
        .i_y   ($signed(AW'(q_y))),
        .i_z   ('0),
        .o_x   (),
        .o_y   (),
        .o_z   (v_z)
    );

    logic [ZPW-1:0] r12_p;
    logic [ZPW-1:0] dsum;
    logic [DW-1:0]  dist_m;

    assign dsum   = r12_p + HALF_Z;
    assign dist_m = DW'(dsum >> F);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // a negative residue counts as zero
            r12_p <= v_z[AW-1] ? '0 : ZPW'(v_z[AW-2:0]) * ZPW'(EARTH_DIAM_M);
            r_ont <= r_nt[L-1];
            if (r_nt[L-1]) begin
                r_od <= '0;
            end else if (dist_m > DW'(MAX_DIST_M)) begin
                r_od <= MAX_DIST_M;
            end else begin
                r_od <= 25'(dist_m);
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/haversine_distance_to_target_top.sv =====
// path from input accept to output valid: front register, queue, angle prep, sine/cosine
// cordic, products, square roots, atan2 cordic, scaling
// throughput: one fix per cycle while m_axis_tready does not stall the back end, set by
// the fully pipelined cordic and square root stages
// reset: synchronous active low, clears target registers, queue and valid flags
`default_nettype none
module haversine_distance_to_target_top #(
    parameter int CORDIC_STEPS        = 24,
    parameter int ANGLE_FRACTION_BITS = 29
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // fix_latitude[30:0], fix_longitude[62:31]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // distance_metres[24:0]
    output logic [0:0]       m_axis_tuser,   // no_target[0]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import hdt_pkg::*;

    t_cfg_wr     cfg;
    t_item       f_item, q_item;
    logic        f_push, q_full, q_valid, q_pop;
    logic [24:0] dist_m;
    logic        no_tgt;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    hdt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_lat   ($signed(s_axis_tdata[30:0])),
        .i_lon   ($signed(s_axis_tdata[62:31])),
        .i_full  (q_full),
        .o_push  (f_push),
        .o_item  (f_item)
    );

    hdt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    hdt_back #(.STEPS(CORDIC_STEPS), .F(ANGLE_FRACTION_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .i_ready     (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_distance  (dist_m),
        .o_no_target (no_tgt)
    );

    assign m_axis_tdata = {7'b0, dist_m};
    assign m_axis_tuser = no_tgt;

`ifndef NO_ASSERTIONS
    a_no_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[24:0] == 25'd0)
        else $error("no_target result with nonzero distance");

    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[24:0] <= MAX_DIST_M)
        else $error("distance above half circumference");

    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full && !q_pop |=> !$past(f_push))
        else $error("push into a full queue");
`endif
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hdt_pkg::*;

    localparam int STEPS = 24;
    localparam int FRAC = 29;
    localparam longint ONE = longint'(1) << FRAC;
    localparam int DRAIN_CYCLES = 2 * STEPS + FRAC + 16 + 20;
    localparam longint CYCLE_LIMIT = 600000;
    localparam int MAX_DIST = 20015087;

    typedef struct {
        logic [24:0] metres;
        logic        no_tgt;
    } t_range;

    class range_predictor;
        t_range      expected_ranges[$];
        longint      ang[STEPS];
        logic [30:0] tgt_lat;
        logic [31:0] tgt_lon;
        logic        tgt_valid;
        int          errors;
        int          checked;

        function new();
            bit [63:0] sum;
            bit [63:0] term;
            int unsigned e;
            for (int i = 0; i < STEPS; i++) begin
                sum = 0;
                if (i == 0) begin
                    sum = (PI_Q62 + 64'd2) >> 2;
                end else begin
                    for (int k = 0; k < 40; k++) begin
                        e = i * (2 * k + 1);
                        if (e <= 62) begin
                            term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                            sum = (k % 2) ? sum - term : sum + term;
                        end
                    end
                end
                ang[i] = longint'((sum + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
            end
            tgt_lat = 0;
            tgt_lon = 0;
            tgt_valid = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_TARGET_LAT) begin
                tgt_lat = val[30:0];
            end else if (idx == CFG_TARGET_LON) begin
                tgt_lon = val;
            end else if (idx == CFG_TARGET_VALID) begin
                tgt_valid = val[0];
            end
        endfunction

        function longint clampv(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void rotate(longint theta, output longint c, output longint s);
            longint x, y, z, dx, dy;
            x = (longint'(INV_GAIN_Q31) + (longint'(1) << (30 - FRAC))) >>> (31 - FRAC);
            y = 0;
            z = theta;
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= ang[i];
                end else begin
                    x += dx; y -= dy; z += ang[i];
                end
            end
            c = clampv(x, -ONE, ONE);
            s = clampv(y, -ONE, ONE);
        endfunction

        function longint vector_angle(longint y, longint x);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += ang[i];
                end else begin
                    x -= dx; y += dy; z -= ang[i];
                end
            end
            return z;
        endfunction

        function longint half_sine(longint d);
            longint m, c, s;
            bit [63:0] rad;
            m = d % longint'(DEG7_FULL);
            if (m < 0) m += longint'(DEG7_FULL);
            if (m > longint'(DEG7_HALF)) m = longint'(DEG7_FULL) - m;
            rad = (64'(m) * RAD_K + (64'd1 << (62 - FRAC))) >> (63 - FRAC);
            rotate(longint'(rad), c, s);
            return clampv(s, 0, ONE);
        endfunction

        function longint lat_cosine(longint lat);
            longint m, c, s;
            bit neg;
            bit [63:0] rad;
            m = (lat < 0) ? -lat : lat;
            neg = 0;
            // past the pole the angle folds back and cosine flips sign
            if (m > longint'(DEG7_QUARTER)) begin
                m = longint'(DEG7_HALF) - m;
                neg = 1;
            end
            rad = (64'(m) * RAD_K + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
            rotate(longint'(rad), c, s);
            return neg ? -c : c;
        endfunction

        function bit [63:0] floor_sqrt(bit [63:0] v);
            bit [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void note_fix(logic [30:0] lat_bits, logic [31:0] lon_bits);
            t_range r;
            longint lat1, lon1, lat2, lon2, s1, s2, c1, c2, cc, u, a, z, full;
            bit [63:0] d;
            full = ONE * ONE;
            if (!tgt_valid) begin
                r.metres = 0;
                r.no_tgt = 1;
            end else begin
                lat1 = longint'($signed(lat_bits));
                lon1 = longint'($signed(lon_bits));
                lat2 = longint'($signed(tgt_lat));
                lon2 = longint'($signed(tgt_lon));
                s1 = half_sine(lat2 - lat1);
                s2 = half_sine(lon2 - lon1);
                c1 = lat_cosine(lat1);
                c2 = lat_cosine(lat2);
                cc = (c1 * c2 + (longint'(1) << (FRAC - 1))) >>> FRAC;
                u = (cc * s2 + (longint'(1) << (FRAC - 1))) >>> FRAC;
                a = clampv(s1 * s1 + u * s2, 0, full);
                z = vector_angle(longint'(floor_sqrt(64'(a))),
                                 longint'(floor_sqrt(64'(full - a))));
                if (z < 0) z = 0;
                d = (64'(z) * 64'(EARTH_DIAM_M) + (64'd1 << (FRAC - 1))) >> FRAC;
                if (d > MAX_DIST) d = MAX_DIST;
                r.metres = d[24:0];
                r.no_tgt = 0;
            end
            expected_ranges.push_back(r);
        endfunction

        function void check_range(logic [24:0] metres, logic no_tgt);
            t_range r;
            if (expected_ranges.size() == 0) begin
                $error("unexpected result item: distance %0d no_target %0b", metres, no_tgt);
                errors++;
                return;
            end
            r = expected_ranges.pop_front();
            checked++;
            if (metres !== r.metres) begin
                $error("distance_metres: expected %0d, actual %0d", r.metres, metres);
                errors++;
            end
            if (no_tgt !== r.no_tgt) begin
                $error("no_target: expected %0b, actual %0b", r.no_tgt, no_tgt);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    range_predictor pred;
    int     tx_idle;
    int     rx_idle;
    longint cycles;
    int     sent;

    haversine_distance_to_target_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        pred = new();
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        m_axis_tready = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_TARGET_LAT;
        i_cfg_data = 0;
        tx_idle = 10;
        rx_idle = 63;
        cycles = 0;
        sent = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pred.note_fix(s_axis_tdata[30:0], s_axis_tdata[62:31]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            pred.check_range(m_axis_tdata[24:0], m_axis_tuser[0]);
    end

    // valid stays up across a burst of writes, the caller drops it
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pred.write_reg(idx, val);
    endtask

    task automatic send_fix(longint lat, longint lon);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {1'b0, lon[31:0], lat[30:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        // switch idling regime by progress through the run
        if (sent == 500) begin
            tx_idle = 63; rx_idle = 10;
        end else if (sent == 1000) begin
            tx_idle = 0; rx_idle = 0;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pred.expected_ranges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_target(longint lat, longint lon, bit vld);
        write_reg(CFG_TARGET_LAT, {1'($urandom_range(1)), lat[30:0]});
        write_reg(CFG_TARGET_LON, lon[31:0]);
        write_reg(CFG_TARGET_VALID, {31'($urandom), vld});
        // index outside the map must leave the target alone
        write_reg(2'd3, $urandom);
        i_cfg_valid <= 0;
    endtask

    task automatic random_fixes(int n, longint tlat, longint tlon);
        longint lat, lon;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                lat = longint'($urandom);
                lon = longint'($urandom);
            end else if (pick < 35) begin
                lat = tlat + longint'($urandom_range(20000)) - 10000;
                lon = tlon + longint'($urandom_range(20000)) - 10000;
            end else begin
                lat = longint'($urandom_range(1800000000)) - 900000000;
                lon = longint'($urandom_range(32'd3600000000)) - 1800000000;
            end
            send_fix(lat, lon);
        end
    endtask

    task automatic directed_fixes(longint tlat, longint tlon);
        send_fix(tlat, tlon);
        send_fix(-tlat, tlon + 1800000000);
        send_fix(900000000, 0);
        send_fix(-900000000, 0);
        send_fix(0, 1800000000);
        send_fix(0, -1800000000);
        send_fix(900000000, 1800000000);
        send_fix(-900000000, -1800000000);
        // raw bit patterns beyond the legal coordinate range
        send_fix(-(longint'(1) << 30), -(longint'(1) << 31));
        send_fix((longint'(1) << 30) - 1, (longint'(1) << 31) - 1);
        send_fix(0, 0);
        send_fix(tlat + 1, tlon);
        send_fix(tlat, tlon - 1);
    endtask

    initial begin
        longint tl;
        longint tn;
        #1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // after reset there is no target
        directed_fixes(0, 0);
        random_fixes(40, 0, 0);
        drain();
        set_target(0, 0, 1);
        directed_fixes(0, 0);
        random_fixes(220, 0, 0);
        drain();
        set_target(900000000, 1800000000, 1);
        directed_fixes(900000000, 1800000000);
        random_fixes(220, 900000000, 1800000000);
        drain();
        set_target(-900000000, -1800000000, 1);
        random_fixes(220, -900000000, -1800000000);
        drain();
        tl = longint'($urandom_range(1800000000)) - 900000000;
        tn = longint'($urandom_range(32'd3600000000)) - 1800000000;
        set_target(tl, tn, 1);
        random_fixes(431, tl, tn);
        drain();
        set_target((longint'(1) << 30) - 1, -(longint'(1) << 31), 1);
        random_fixes(220, 0, 0);
        drain();
        set_target(tl, tn, 0);
        random_fixes(60, tl, tn);
        drain();
        $display("tb: %0d fixes sent, %0d distances checked over 7 target settings",
                 sent, pred.checked);
        $display("tb: covered no target, poles, antimeridian, raw bit patterns, stalls");
        if (pred.errors == 0 && pred.expected_ranges.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
